FILE: rtl/core/scsc_pkg.sv
package scsc_pkg;

  localparam int NUM_CHANNELS = 5;
  localparam int NUM_POS_FIELDS = 5;
  localparam int PRESET_LEN = 5;

  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam logic [11:0] POT_FULL = 12'd4095;
  localparam logic [2:0] SEL_ALL = 3'd5;

  // item commands; code 3 means nothing
  localparam logic [1:0] CMD_KEY = 2'd0;
  localparam logic [1:0] CMD_POT = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // configuration register indexes
  localparam logic CFG_SLEW_STEP = 1'b0;
  localparam logic CFG_NUDGE_AMOUNT = 1'b1;

  localparam logic [7:0] SLEW_STEP_RESET = 8'd4;
  localparam logic [7:0] NUDGE_AMOUNT_RESET = 8'd30;

  // remote key codes
  localparam logic [7:0] KEY_MODE_KEYPAD = 8'h42;
  localparam logic [7:0] KEY_MODE_POT = 8'h4a;
  localparam logic [7:0] KEY_MODE_DEMO1 = 8'h5a;
  localparam logic [7:0] KEY_MODE_DEMO2 = 8'h52;
  localparam logic [7:0] KEY_PRESET_ROCK = 8'h08;
  localparam logic [7:0] KEY_PRESET_POINT = 8'h1c;
  localparam logic [7:0] KEY_PRESET_OK = 8'h40;
  localparam logic [7:0] KEY_NUDGE_DOWN = 8'h46;
  localparam logic [7:0] KEY_NUDGE_UP = 8'h15;
  localparam logic [7:0] KEY_SET_MIN = 8'h44;
  localparam logic [7:0] KEY_SET_MAX = 8'h43;
  localparam logic [7:0] KEY_SEL_0 = 8'h16;
  localparam logic [7:0] KEY_SEL_1 = 8'h19;
  localparam logic [7:0] KEY_SEL_2 = 8'h0d;
  localparam logic [7:0] KEY_SEL_3 = 8'h0c;
  localparam logic [7:0] KEY_SEL_4 = 8'h18;
  localparam logic [7:0] KEY_SEL_ALL = 8'h5e;

  localparam logic [7:0] PRESET_ROCK [PRESET_LEN] = '{8'd0, 8'd0, 8'd180, 8'd180, 8'd0};
  localparam logic [7:0] PRESET_POINT [PRESET_LEN] = '{8'd0, 8'd0, 8'd180, 8'd180, 8'd180};
  localparam logic [7:0] PRESET_OK [PRESET_LEN] = '{8'd180, 8'd180, 8'd0, 8'd0, 8'd0};

  typedef enum logic [1:0] {
    MODE_KEYPAD = 2'd0,
    MODE_POT = 2'd1,
    MODE_DEMO1 = 2'd2,
    MODE_DEMO2 = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] key_code;
    logic [2:0] channel;
    logic [11:0] pot_value;
  } item_t;

  typedef struct packed {
    logic [7:0] position_0;
    logic [7:0] position_1;
    logic [7:0] position_2;
    logic [7:0] position_3;
    logic [7:0] position_4;
    logic [1:0] mode_now;
    logic [2:0] selected_now;
  } result_t;

  // per-channel update control
  typedef struct packed {
    logic load;
    logic [7:0] value;
    logic nudge;
    logic up;
    logic tick;
  } chan_ctl_t;

endpackage

FILE: rtl/core/scsc_channel.sv
module scsc_channel
  import scsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  chan_ctl_t ctl,
  input  logic [7:0] slew_step,
  input  logic [7:0] nudge_amount,
  output logic [7:0] position_next
);

  logic [7:0] target;
  logic [7:0] current;
  logic [7:0] target_next;
  logic [8:0] sum;
  logic [7:0] diff;

  always_comb begin
    sum = {1'b0, target} + {1'b0, nudge_amount};
    target_next = target;
    if (ctl.load) begin
      target_next = ctl.value;
    end else if (ctl.nudge) begin
      if (ctl.up) begin
        target_next = (sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : sum[7:0];
      end else begin
        target_next = (nudge_amount > target) ? 8'd0 : target - nudge_amount;
      end
    end
  end

  // step toward target, land on it when within one step
  always_comb begin
    diff = 8'd0;
    position_next = current;
    if (ctl.tick) begin
      if (current < target) begin
        diff = target - current;
        position_next = (diff <= slew_step) ? target : current + slew_step;
      end else if (current > target) begin
        diff = current - target;
        position_next = (diff <= slew_step) ? target : current - slew_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= 8'd0;
      current <= 8'd0;
    end else if (en) begin
      target <= target_next;
      current <= position_next;
    end
  end

endmodule

FILE: rtl/core/servo_command_slew_controller.sv
// Channel  Direction  Handshake                     Beat
// item     in         item_valid / item_stall       item_t: cmd, key_code, channel, pot_value
// result   out        result_valid / result_stall   result_t: positions, mode, selection
// cfg      in         cfg_valid / cfg_ready         cfg_index selects register, cfg_data value
//
// One item per cycle sustained while the result beat is not stalled; each accepted item goes
// through the input register, then all decode, pot scaling and slewing in one pass into the
// result register. rst is synchronous: targets and positions 0, pot mode, all channels
// selected, slew step 4, nudge 30. A stalled result holds the pipe; item_stall rises only
// when both registers are full and the result beat is stalled. cfg_ready is always high.
module servo_command_slew_controller
  import scsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  item_t item,
  output logic result_valid,
  input  logic result_stall,
  output result_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [7:0] cfg_data
);

  logic s1_valid;
  item_t s1_item;
  logic advance;

  logic [7:0] slew_step;
  logic [7:0] nudge_amount;
  mode_t mode;
  mode_t mode_next;
  logic [2:0] selected;
  logic [2:0] selected_next;

  logic preset_rock;
  logic preset_point;
  logic preset_ok;
  logic keypad;
  logic is_key;
  logic [19:0] pot_scaled;
  logic [7:0] pot_q0;
  logic [12:0] pot_rem;
  logic [7:0] pot_target;

  chan_ctl_t ctl [NUM_CHANNELS];
  logic [7:0] pos_next [NUM_CHANNELS];
  logic [7:0] pos_field [NUM_POS_FIELDS];

  assign cfg_ready = 1'b1;
  assign advance = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      slew_step <= SLEW_STEP_RESET;
      nudge_amount <= NUDGE_AMOUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLEW_STEP: slew_step <= cfg_data;
        CFG_NUDGE_AMOUNT: nudge_amount <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  // pot * 180 / 4095: quotient by 4096, remainder below twice 4095, one correction
  always_comb begin
    pot_scaled = 20'(s1_item.pot_value) * 20'(ANGLE_MAX);
    pot_q0 = pot_scaled[19:12];
    pot_rem = {1'b0, pot_scaled[11:0]} + 13'(pot_q0);
    pot_target = (pot_rem >= 13'(POT_FULL)) ? pot_q0 + 8'd1 : pot_q0;
  end

  always_comb begin
    is_key = (s1_item.cmd == CMD_KEY);
    preset_rock = is_key && (s1_item.key_code == KEY_PRESET_ROCK);
    preset_point = is_key && (s1_item.key_code == KEY_PRESET_POINT);
    preset_ok = is_key && (s1_item.key_code == KEY_PRESET_OK);
    mode_next = mode;
    if (is_key) begin
      case (s1_item.key_code)
        KEY_MODE_KEYPAD: mode_next = MODE_KEYPAD;
        KEY_MODE_POT: mode_next = MODE_POT;
        KEY_MODE_DEMO1: mode_next = MODE_DEMO1;
        KEY_MODE_DEMO2: mode_next = MODE_DEMO2;
        KEY_PRESET_ROCK, KEY_PRESET_POINT, KEY_PRESET_OK: mode_next = MODE_KEYPAD;
        default: ;
      endcase
    end
    keypad = is_key && (mode_next == MODE_KEYPAD);
    selected_next = selected;
    if (keypad) begin
      case (s1_item.key_code)
        KEY_SEL_0: selected_next = 3'd0;
        KEY_SEL_1: selected_next = 3'd1;
        KEY_SEL_2: selected_next = 3'd2;
        KEY_SEL_3: selected_next = 3'd3;
        KEY_SEL_4: selected_next = 3'd4;
        KEY_SEL_ALL: selected_next = SEL_ALL;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    logic hit;
    logic [7:0] preset_value;
    logic preset_load;
    logic set_key;
    logic pot_hit;

    if (i < PRESET_LEN) begin : g_preset
      assign preset_load = preset_rock || preset_point || preset_ok;
      assign preset_value = preset_rock ? PRESET_ROCK[i] :
                            preset_point ? PRESET_POINT[i] : PRESET_OK[i];
    end else begin : g_no_preset
      assign preset_load = 1'b0;
      assign preset_value = 8'd0;
    end

    always_comb begin
      hit = (selected == SEL_ALL) || (selected == 3'(i));
      set_key = keypad && hit && ((s1_item.key_code == KEY_SET_MIN) ||
                                  (s1_item.key_code == KEY_SET_MAX));
      pot_hit = (s1_item.cmd == CMD_POT) && (mode == MODE_POT) &&
                (s1_item.channel == 3'(i));
      ctl[i].load = preset_load || set_key || pot_hit;
      if (preset_load) begin
        ctl[i].value = preset_value;
      end else if (pot_hit) begin
        ctl[i].value = pot_target;
      end else begin
        ctl[i].value = (s1_item.key_code == KEY_SET_MAX) ? ANGLE_MAX : 8'd0;
      end
      ctl[i].nudge = keypad && hit && ((s1_item.key_code == KEY_NUDGE_DOWN) ||
                                       (s1_item.key_code == KEY_NUDGE_UP));
      ctl[i].up = (s1_item.key_code == KEY_NUDGE_UP);
      ctl[i].tick = (s1_item.cmd == CMD_TICK);
    end

    scsc_channel u_channel (
      .clk(clk),
      .rst(rst),
      .en(advance),
      .ctl(ctl[i]),
      .slew_step(slew_step),
      .nudge_amount(nudge_amount),
      .position_next(pos_next[i])
    );
  end

  for (genvar j = 0; j < NUM_POS_FIELDS; j++) begin : g_field
    if (j < NUM_CHANNELS) begin : g_used
      assign pos_field[j] = pos_next[j];
    end else begin : g_unused
      assign pos_field[j] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_POT;
      selected <= SEL_ALL;
    end else if (advance) begin
      mode <= mode_next;
      selected <= selected_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.position_0 <= pos_field[0];
      result.position_1 <= pos_field[1];
      result.position_2 <= pos_field[2];
      result.position_3 <= pos_field[3];
      result.position_4 <= pos_field[4];
      result.mode_now <= mode_next;
      result.selected_now <= selected_next;
    end
  end

endmodule
